// File: design/kwm_pkg.sv
// Shared types and constants for the k-way merge with key colour union.
// Used by every module of the block; depends on nothing else.
package kwm_pkg;

    localparam int KEY_W         = 64;
    localparam int STREAMS_DEF   = 8;
    localparam int MAX_CW_DEF    = 7;
    localparam int ACTIVE_W      = 4;
    localparam int COLORS_W      = 3;
    localparam int FILL_W        = 4;
    localparam int STREAM_FLD_W  = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STREAMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_WORDS    = 1'b1;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic [STREAM_FLD_W-1:0] stream;
        logic                    end_of_stream;
        logic [KEY_W-1:0]        word;
    } in_t;

    typedef struct packed {
        logic                    kind;
        logic [KEY_W-1:0]        out_word;
        logic [STREAM_FLD_W-1:0] request_stream;
        logic                    last;
        logic                    done_res;
    } out_t;

endpackage

// File: design/kwm_head_store.sv
// Head record store: one record slot per stream, one write and one read port.
// Depends on kwm_pkg for the word width.
module kwm_head_store
    import kwm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [KEY_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [KEY_W-1:0] rdata
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/kwm_acc_store.sv
// Pending output record store with per-word valid bits, so that a new record
// reads as zero without a clearing sweep. Depends on kwm_pkg.
module kwm_acc_store
    import kwm_pkg::*;
#(
    parameter int DEPTH = 57,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [KEY_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [KEY_W-1:0] rdata
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

// File: design/kway_merge_key_color_union_core.sv
// K-way merge of sorted record streams with duplicate-key colour union.
// Holds the sequencer, the shared key comparator and the stream bookkeeping.
// Depends on kwm_pkg, kwm_head_store and kwm_acc_store.
//
// Usage: each input item carries one word of one stream (key, then colour
// words) or an end-of-stream mark. Result items are refill requests and
// merged record words on the output channel. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// One input item at a time is processed; in_ready is high only when idle.
// An item that does not complete all heads goes straight back to idle. A
// pick runs a serial key scan through the single head memory read port,
// reading the key of each live stream and passing over each ended one,
// then decides, opens a new record when the key changes, copies each
// colour word with a read and a write, and issues the request. A new key
// first emits the pending record (1 + active_streams * color_words words),
// read from the record store. Flushing at end of all streams does the same.
// When the receiver stalls, the output register holds its item and the
// sequencer waits. Reset clears all heads, end marks and the pending record,
// and restores active_streams to 2 and color_words to 1; no clearing pass.
module kway_merge_key_color_union_core
    import kwm_pkg::*;
#(
    parameter int STREAMS         = STREAMS_DEF,
    parameter int MAX_COLOR_WORDS = MAX_CW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_item
);

    localparam int SLOT_WORDS = MAX_COLOR_WORDS + 1;
    localparam int HEAD_DEPTH = STREAMS * SLOT_WORDS;
    localparam int HAW        = $clog2(HEAD_DEPTH);
    localparam int ACC_DEPTH  = 1 + STREAMS * MAX_COLOR_WORDS;
    localparam int AAW        = $clog2(ACC_DEPTH);
    localparam int SW         = $clog2(STREAMS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EVAL     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_NEWREC   = 4'd5;
    localparam logic [3:0] S_COPY_RD  = 4'd6;
    localparam logic [3:0] S_COPY_WR  = 4'd7;
    localparam logic [3:0] S_REQ      = 4'd8;
    localparam logic [3:0] S_EMIT_RD  = 4'd9;
    localparam logic [3:0] S_EMIT_WR  = 4'd10;

    logic [3:0]             state_reg, state_next;
    logic [ACTIVE_W-1:0]    active_reg;
    logic [COLORS_W-1:0]    colors_reg;
    logic [FILL_W-1:0]      fill_reg [STREAMS];
    logic [STREAMS-1:0]     ended_reg;
    logic                   accum_valid_reg, accum_valid_next;
    logic [KEY_W-1:0]       prev_key_reg, prev_key_next;
    logic [KEY_W-1:0]       bkey_reg, bkey_next;
    logic [SW-1:0]          best_reg, best_next;
    logic                   best_valid_reg, best_valid_next;
    logic [SW-1:0]          scan_reg, scan_next;
    logic [COLORS_W-1:0]    copy_reg, copy_next;
    logic [AAW-1:0]         emit_reg, emit_next;
    logic                   flush_reg, flush_next;
    logic                   out_valid_reg;
    out_t                   out_item_reg;

    logic [ACTIVE_W-1:0]    na;
    logic [COLORS_W-1:0]    cw;
    logic [FILL_W-1:0]      need;
    logic [AAW-1:0]         last_word;
    logic                   live;
    logic                   allfull;
    logic                   out_free;
    logic                   load_out;
    out_t                   load_item;
    logic                   accept;
    logic [SW-1:0]          in_s;
    logic                   in_take;
    logic                   head_we;
    logic [HAW-1:0]         head_waddr;
    logic                   head_re;
    logic [HAW-1:0]         head_raddr;
    logic [KEY_W-1:0]       head_rdata;
    logic                   acc_clear;
    logic                   acc_we;
    logic [AAW-1:0]         acc_waddr;
    logic [KEY_W-1:0]       acc_wdata;
    logic                   acc_re;
    logic [KEY_W-1:0]       acc_rdata;
    logic                   scan_last;
    logic                   clear_best_fill;

    // Effective register values, clamped to the supported range.
    always_comb
    begin
        na = active_reg;
        if (active_reg == '0)
        begin
            na = ACTIVE_W'(1);
        end
        else if (active_reg > ACTIVE_W'(STREAMS))
        begin
            na = ACTIVE_W'(STREAMS);
        end
        cw = colors_reg;
        if (colors_reg == '0)
        begin
            cw = COLORS_W'(1);
        end
        else if (colors_reg > COLORS_W'(MAX_COLOR_WORDS))
        begin
            cw = COLORS_W'(MAX_COLOR_WORDS);
        end
    end

    assign need      = FILL_W'(cw) + FILL_W'(1);
    assign last_word = AAW'(na) * AAW'(cw);
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_s      = in_item.stream[SW-1:0];
    assign in_take   = accept && (ACTIVE_W'(in_item.stream) < na) && !ended_reg[in_s];
    assign head_we   = in_take && !in_item.end_of_stream && (fill_reg[in_s] < need);
    assign head_waddr = HAW'(in_s) * HAW'(SLOT_WORDS) + HAW'(fill_reg[in_s]);
    assign scan_last = (ACTIVE_W'(scan_reg) == na - ACTIVE_W'(1));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        live    = 1'b0;
        allfull = 1'b1;
        for (int i = 0; i < STREAMS; i++)
        begin
            if ((ACTIVE_W'(i) < na) && !ended_reg[i])
            begin
                live = 1'b1;
                if (fill_reg[i] < need)
                begin
                    allfull = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        accum_valid_next = accum_valid_reg;
        prev_key_next    = prev_key_reg;
        bkey_next        = bkey_reg;
        best_next        = best_reg;
        best_valid_next  = best_valid_reg;
        scan_next        = scan_reg;
        copy_next        = copy_reg;
        emit_next        = emit_reg;
        flush_next       = flush_reg;
        head_re          = 1'b0;
        head_raddr       = '0;
        acc_clear        = 1'b0;
        acc_we           = 1'b0;
        acc_waddr        = '0;
        acc_wdata        = head_rdata;
        acc_re           = 1'b0;
        load_out         = 1'b0;
        load_item        = '0;
        clear_best_fill  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (live && allfull)
                begin
                    scan_next       = '0;
                    best_valid_next = 1'b0;
                    state_next      = S_SCAN_RD;
                end
                else if (!live && accum_valid_reg)
                begin
                    flush_next = 1'b1;
                    emit_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                if (ended_reg[scan_reg])
                begin
                    if (scan_last)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        scan_next = scan_reg + SW'(1);
                    end
                end
                else
                begin
                    head_re    = 1'b1;
                    head_raddr = HAW'(scan_reg) * HAW'(SLOT_WORDS);
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                // Strict less-than keeps the lowest stream on equal keys.
                if (!best_valid_reg || (head_rdata < bkey_reg))
                begin
                    bkey_next       = head_rdata;
                    best_next       = scan_reg;
                    best_valid_next = 1'b1;
                end
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                copy_next = '0;
                if (accum_valid_reg && (bkey_reg == prev_key_reg))
                begin
                    state_next = S_COPY_RD;
                end
                else if (accum_valid_reg)
                begin
                    flush_next = 1'b0;
                    emit_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_NEWREC;
                end
            end
            S_NEWREC:
            begin
                acc_clear        = 1'b1;
                acc_we           = 1'b1;
                acc_waddr        = '0;
                acc_wdata        = bkey_reg;
                accum_valid_next = 1'b1;
                copy_next        = '0;
                state_next       = S_COPY_RD;
            end
            S_COPY_RD:
            begin
                head_re    = 1'b1;
                head_raddr = HAW'(best_reg) * HAW'(SLOT_WORDS) + HAW'(copy_reg) + HAW'(1);
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                acc_we    = 1'b1;
                acc_waddr = AAW'(1) + AAW'(best_reg) * AAW'(cw) + AAW'(copy_reg);
                if (copy_reg == cw - COLORS_W'(1))
                begin
                    state_next = S_REQ;
                end
                else
                begin
                    copy_next  = copy_reg + COLORS_W'(1);
                    state_next = S_COPY_RD;
                end
            end
            S_REQ:
            begin
                if (out_free)
                begin
                    load_out                 = 1'b1;
                    load_item.kind           = KIND_REQUEST;
                    load_item.request_stream = STREAM_FLD_W'(best_reg);
                    load_item.last           = 1'b1;
                    prev_key_next            = bkey_reg;
                    clear_best_fill          = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                acc_re     = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    load_item.kind     = KIND_WORD;
                    load_item.out_word = acc_rdata;
                    load_item.last     = flush_reg && (emit_reg == last_word);
                    load_item.done_res = flush_reg;
                    if (emit_reg == last_word)
                    begin
                        if (flush_reg)
                        begin
                            accum_valid_next = 1'b0;
                            state_next       = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_NEWREC;
                        end
                    end
                    else
                    begin
                        emit_next  = emit_reg + AAW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_reg      <= ACTIVE_W'(2);
            colors_reg      <= COLORS_W'(1);
            ended_reg       <= '0;
            accum_valid_reg <= 1'b0;
            prev_key_reg    <= '1;
            best_valid_reg  <= 1'b0;
            flush_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < STREAMS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            accum_valid_reg <= accum_valid_next;
            prev_key_reg    <= prev_key_next;
            best_valid_reg  <= best_valid_next;
            flush_reg       <= flush_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACTIVE_STREAMS: active_reg <= cfg_data[ACTIVE_W-1:0];
                    CFG_COLOR_WORDS:    colors_reg <= cfg_data[COLORS_W-1:0];
                    default:            active_reg <= active_reg;
                endcase
            end
            if (in_take)
            begin
                if (in_item.end_of_stream)
                begin
                    ended_reg[in_s] <= 1'b1;
                    fill_reg[in_s]  <= '0;
                end
                else if (head_we)
                begin
                    fill_reg[in_s] <= fill_reg[in_s] + FILL_W'(1);
                end
            end
            if (clear_best_fill)
            begin
                fill_reg[best_reg] <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bkey_reg <= bkey_next;
        best_reg <= best_next;
        scan_reg <= scan_next;
        copy_reg <= copy_next;
        emit_reg <= emit_next;
        if (load_out)
        begin
            out_item_reg <= load_item;
        end
    end

    kwm_head_store #(
        .DEPTH (HEAD_DEPTH),
        .AW    (HAW)
    ) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (in_item.word),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    kwm_acc_store #(
        .DEPTH (ACC_DEPTH),
        .AW    (AAW)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (acc_clear),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (emit_reg),
        .rdata (acc_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A pending record is dropped only by the final word of a flush.
    a_accum_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(accum_valid_reg) |-> $past(state_reg == S_EMIT_WR) && $past(flush_reg))
        else $error("pending record dropped outside a flush");

    // Every refill request closes the results of its input item.
    a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == KIND_REQUEST) |-> out_item.last && !out_item.done_res)
        else $error("request item without last or with done");

    // Colours are only ever copied from a stream that is still live.
    a_copy_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_WR) |-> !ended_reg[best_reg] && best_valid_reg)
        else $error("copy from an ended stream");

    // No new input item is taken while results are still being produced.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_WR) || (state_reg == S_REQ) |-> !in_ready)
        else $error("input accepted while busy");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the k-way merge with key colour union.
// Predicts every result item from its own copy of the merge state; needs kwm_pkg and the core.
module tb_top;
    import kwm_pkg::*;

    localparam int NS  = 8;
    localparam int NCW = 7;
    localparam int ACC_N = 1 + NS * NCW;
    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_t in_item;
    logic out_valid;
    logic out_ready;
    out_t out_item;

    kway_merge_key_color_union_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    // Predicted merge state.
    logic [63:0] head_word[NS][NCW+1];
    int unsigned head_cnt[NS];
    bit          ended[NS];
    logic [63:0] pend_rec[ACC_N];
    bit          pend_valid;
    logic [63:0] pend_key;
    int unsigned reg_active;
    int unsigned reg_colors;

    out_t expected_q[$];
    int   refill_q[$];
    int   mismatches;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   stall_left;
    int   cycles;

    // Keys prepared per stream for a merge.
    logic [63:0] key_list[NS][32];
    int          key_total[NS];
    int          key_next[NS];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_word(logic [63:0] w);
        out_t r;
        r = '0;
        r.kind = KIND_WORD;
        r.out_word = w;
        expected_q.push_back(r);
    endfunction

    // Applies one accepted item to the predicted state and queues its results.
    // Returns the stream whose refill is requested, or -1.
    function automatic int merge_step(in_t it);
        int na;
        int cw;
        int need;
        int live;
        int best;
        int first;
        int req;
        bit allfull;
        bit flushed;
        logic [63:0] bkey;
        out_t r;
        na = (reg_active < 1) ? 1 : ((reg_active > NS) ? NS : reg_active);
        cw = (reg_colors < 1) ? 1 : ((reg_colors > NCW) ? NCW : reg_colors);
        need = 1 + cw;
        first = expected_q.size();
        req = -1;
        flushed = 1'b0;
        if (it.stream < na && !ended[it.stream])
        begin
            if (it.end_of_stream)
            begin
                ended[it.stream] = 1'b1;
                head_cnt[it.stream] = 0;
            end
            else if (head_cnt[it.stream] < need)
            begin
                head_word[it.stream][head_cnt[it.stream]] = it.word;
                head_cnt[it.stream]++;
            end
        end
        live = 0;
        allfull = 1'b1;
        for (int i = 0; i < na; i++)
        begin
            if (!ended[i])
            begin
                live++;
                if (head_cnt[i] < need)
                    allfull = 1'b0;
            end
        end
        if (live > 0 && allfull)
        begin
            best = -1;
            bkey = '0;
            for (int i = 0; i < na; i++)
            begin
                if (!ended[i] && (best < 0 || head_word[i][0] < bkey))
                begin
                    best = i;
                    bkey = head_word[i][0];
                end
            end
            if (!(pend_valid && bkey == pend_key))
            begin
                if (pend_valid)
                    for (int i = 0; i < 1 + na * cw; i++)
                        push_word(pend_rec[i]);
                for (int i = 0; i < ACC_N; i++)
                    pend_rec[i] = '0;
                pend_rec[0] = bkey;
                pend_valid = 1'b1;
            end
            for (int i = 0; i < cw; i++)
                pend_rec[1 + best * cw + i] = head_word[best][1 + i];
            pend_key = bkey;
            head_cnt[best] = 0;
            r = '0;
            r.kind = KIND_REQUEST;
            r.request_stream = best[STREAM_FLD_W-1:0];
            expected_q.push_back(r);
            req = best;
        end
        else if (live == 0 && pend_valid)
        begin
            for (int i = 0; i < 1 + na * cw; i++)
                push_word(pend_rec[i]);
            pend_valid = 1'b0;
            flushed = 1'b1;
        end
        if (expected_q.size() > first)
        begin
            expected_q[expected_q.size() - 1].last = 1'b1;
            for (int k = first; k < expected_q.size(); k++)
                expected_q[k].done_res = flushed;
        end
        return req;
    endfunction

    // Offers one item and waits for it to be taken; refill requests are remembered.
    task automatic send_item(logic [2:0] s, logic eos, logic [63:0] w);
        in_t it;
        int req;
        it.stream = s;
        it.end_of_stream = eos;
        it.word = w;
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do
            @(posedge clk);
        while (!in_ready);
        req = merge_step(it);
        if (req >= 0)
            refill_q.push_back(req);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait (expected_q.size() == 0);
        repeat (300) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_ACTIVE_STREAMS)
            reg_active = val;
        else
            reg_colors = val & 3'h7;
    endtask

    // Sends the next record of a stream, or its end mark once the list is spent.
    task automatic send_record(int s, int cw);
        if (key_next[s] >= key_total[s])
            send_item(s[2:0], 1'b1, rand64());
        else
        begin
            send_item(s[2:0], 1'b0, key_list[s][key_next[s]]);
            for (int i = 0; i < cw; i++)
                send_item(s[2:0], 1'b0, rand64());
            key_next[s]++;
        end
    endtask

    // Builds sorted key lists with frequent duplicates across streams, then
    // answers every refill request until all given streams have ended.
    task automatic run_merge(int lo, int hi, int cw, int max_rec, bit add_max_key,
                             bit switch_modes);
        logic [63:0] k;
        logic [63:0] base;
        int s;
        int fed;
        int total;
        base = rand64() & 64'hFFFF_FFFF_FFFF_E000;
        total = 0;
        for (int i = lo; i < hi; i++)
        begin
            k = base;
            key_total[i] = $urandom_range(1, max_rec);
            key_next[i] = 0;
            for (int j = 0; j < key_total[i]; j++)
            begin
                k = k + $urandom_range(0, 2);
                key_list[i][j] = k;
            end
            if (add_max_key)
                key_list[i][key_total[i] - 1] = KEY_MAX;
            total += key_total[i];
        end
        fed = 0;
        refill_q.delete();
        for (int i = lo; i < hi; i++)
            send_record(i, cw);
        while (refill_q.size() > 0)
        begin
            if (switch_modes)
            begin
                if (fed < total / 3)
                begin
                    send_gap_pct = 21;
                    recv_gap_pct = 45;
                end
                else if (fed < 2 * total / 3)
                begin
                    send_gap_pct = 45;
                    recv_gap_pct = 21;
                end
                else
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            end
            // Noise on streams that have already ended; the block must ignore it.
            if ($urandom_range(9) == 0)
                send_item(3'($urandom_range(0, lo - 1)), 1'($urandom_range(1)), rand64());
            s = refill_q.pop_front();
            send_record(s, cw);
            fed++;
        end
    endtask

    // Equal keys, the all-ones key, ignored words, a partial head and flushing.
    task automatic test_directed();
        send_item(3'd2, 1'b0, 64'h0);
        send_item(3'd0, 1'b0, 64'h5);
        send_item(3'd0, 1'b0, 64'hAAAA_5555_AAAA_5555);
        send_item(3'd0, 1'b0, 64'h1234);
        send_item(3'd1, 1'b0, 64'h5);
        send_item(3'd1, 1'b0, 64'h5555_AAAA_5555_AAAA);
        send_item(3'd0, 1'b0, KEY_MAX);
        send_item(3'd0, 1'b0, KEY_MAX);
        send_item(3'd1, 1'b0, 64'h7);
        send_item(3'd1, 1'b1, 64'h0);
        send_item(3'd0, 1'b1, 64'h0);
        send_item(3'd0, 1'b1, 64'h0);
        send_item(3'd1, 1'b0, 64'h9);
    endtask

    // Widest records on two fresh streams.
    task automatic test_wide_records();
        write_reg(CFG_ACTIVE_STREAMS, 4'd4);
        write_reg(CFG_COLOR_WORDS, 4'd7);
        run_merge(2, 4, 7, 2, 1'b1, 1'b0);
    endtask

    // Register values below range clamp to one stream and one colour word.
    task automatic test_clamped_low();
        write_reg(CFG_ACTIVE_STREAMS, 4'd1);
        write_reg(CFG_ACTIVE_STREAMS, 4'd0);
        write_reg(CFG_COLOR_WORDS, 4'd0);
        for (int i = 0; i < 6; i++)
            send_item(3'($urandom_range(0, 7)), 1'($urandom_range(1)), rand64());
    endtask

    // Long merge over the remaining streams, with the count clamped from above,
    // a long output stall at the start and every idling mode in turn.
    task automatic test_long_merge();
        write_reg(CFG_COLOR_WORDS, 4'd2);
        write_reg(CFG_ACTIVE_STREAMS, 4'd15);
        stall_left = 400;
        run_merge(4, 8, 2, 12, 1'b0, 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind=%0d word=%h req=%0d last=%0d done=%0d",
                             out_item.kind, out_item.out_word, out_item.request_stream,
                             out_item.last, out_item.done_res);
            end
            else
            begin
                out_t e;
                e = expected_q.pop_front();
                if (out_item.kind !== e.kind || out_item.out_word !== e.out_word
                    || out_item.request_stream !== e.request_stream
                    || out_item.last !== e.last || out_item.done_res !== e.done_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp kind=%0d word=%h req=%0d last=%0d done=%0d",
                                 e.kind, e.out_word, e.request_stream, e.last, e.done_res);
                        $display("          got kind=%0d word=%h req=%0d last=%0d done=%0d",
                                 out_item.kind, out_item.out_word, out_item.request_stream,
                                 out_item.last, out_item.done_res);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        stall_left = 0;
        send_gap_pct = 21;
        recv_gap_pct = 45;
        reg_active = 2;
        reg_colors = 1;
        pend_valid = 1'b0;
        pend_key = KEY_MAX;
        for (int i = 0; i < NS; i++)
        begin
            head_cnt[i] = 0;
            ended[i] = 1'b0;
            for (int j = 0; j <= NCW; j++)
                head_word[i][j] = '0;
        end
        for (int i = 0; i < ACC_N; i++)
            pend_rec[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_wide_records();
        test_clamped_low();
        test_long_merge();

        wait (expected_q.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
design/kwm_pkg.sv
design/kwm_head_store.sv
design/kwm_acc_store.sv
design/kway_merge_key_color_union_core.sv
sim/tb_top.sv
